@@ src/bqc_pkg.sv @@
package bqc_pkg;

	// Micro-operations of one section, in issue order.
	typedef enum logic [2:0] {
		OP_Y,   // y   = s0 + b0*x
		OP_T1,  // acc = b1*x
		OP_T2,  // acc = acc + (-a1)*y
		OP_S0,  // s0  = s1 + acc
		OP_P2,  // acc = b2*x
		OP_S1   // s1  = acc + (-a2)*y
	} op_e;

	typedef enum logic [2:0] {
		CF_B0,
		CF_B1,
		CF_B2,
		CF_A1,
		CF_A2,
		CF_ONE
	} coef_e;

	typedef enum logic [1:0] {
		SRC_X,
		SRC_Y,
		SRC_ACC
	} src_e;

	typedef enum logic [1:0] {
		ADD_ZERO,
		ADD_S0,
		ADD_S1,
		ADD_ACC
	} add_e;

	typedef enum logic [1:0] {
		DST_Y,
		DST_ACC,
		DST_S0,
		DST_S1
	} dst_e;

	typedef struct packed {
		coef_e coef;
		src_e  src;
		add_e  add;
		dst_e  dst;
	} uop_t;

	// Sequencer to datapath control.
	typedef struct packed {
		logic start;
		logic emit;
		op_e  op;
	} seq_ctl_t;

	localparam logic signed [31:0] Q28_ONE = 32'sh1000_0000;
	localparam int ROM_ROWS = 5;

	// Columns: b0, b1, b2, -a1, -a2 in signed Q4.28.
	localparam logic signed [31:0] COEF_ROM [ROM_ROWS][5] = '{
		'{32'sd147504, -32'sd295009, 32'sd147504, -32'sd208239557, -32'sd156314714},
		'{32'sd268435456, -32'sd536870912, 32'sd268435456, -32'sd148770661,
			-32'sd169236430},
		'{32'sd268435456, 32'sd0, -32'sd268435456, -32'sd278033113, -32'sd182786864},
		'{32'sd268435456, 32'sd536870912, 32'sd268435456, -32'sd121451890,
			-32'sd225400456},
		'{32'sd268435456, 32'sd536870912, 32'sd268435456, -32'sd340380561,
			-32'sd235077388}
	};

	function automatic uop_t uop_of(op_e op);
		uop_t u;
		unique case (op)
			OP_Y:    u = '{coef: CF_B0,  src: SRC_X,   add: ADD_S0,   dst: DST_Y};
			OP_T1:   u = '{coef: CF_B1,  src: SRC_X,   add: ADD_ZERO, dst: DST_ACC};
			OP_T2:   u = '{coef: CF_A1,  src: SRC_Y,   add: ADD_ACC,  dst: DST_ACC};
			OP_S0:   u = '{coef: CF_ONE, src: SRC_ACC, add: ADD_S1,   dst: DST_S0};
			OP_P2:   u = '{coef: CF_B2,  src: SRC_X,   add: ADD_ZERO, dst: DST_ACC};
			OP_S1:   u = '{coef: CF_A2,  src: SRC_Y,   add: ADD_ACC,  dst: DST_S1};
			default: u = '{coef: CF_ONE, src: SRC_X,   add: ADD_ZERO, dst: DST_ACC};
		endcase
		return u;
	endfunction

	function automatic op_e op_next(op_e op);
		op_e n;
		unique case (op)
			OP_Y:    n = OP_T1;
			OP_T1:   n = OP_T2;
			OP_T2:   n = OP_S0;
			OP_S0:   n = OP_P2;
			OP_P2:   n = OP_S1;
			default: n = OP_Y;
		endcase
		return n;
	endfunction

	// Sections past the table pass the signal straight through.
	function automatic logic signed [31:0] coef_of(int unsigned sec, coef_e k);
		logic signed [31:0] c;
		if (k == CF_ONE) begin
			c = Q28_ONE;
		end else if (sec >= ROM_ROWS) begin
			c = (k == CF_B0) ? Q28_ONE : 32'sd0;
		end else begin
			unique case (k)
				CF_B0:   c = COEF_ROM[sec][0];
				CF_B1:   c = COEF_ROM[sec][1];
				CF_B2:   c = COEF_ROM[sec][2];
				CF_A1:   c = COEF_ROM[sec][3];
				CF_A2:   c = COEF_ROM[sec][4];
				default: c = Q28_ONE;
			endcase
		end
		return c;
	endfunction

endpackage

@@ src/bqc_mac.sv @@
// Shared multiply-saturate-add unit: result = sat(addend + sat(floor(coef*operand / 2^28))).
// The product is built from two 32x33 partial products on one multiplier.
module bqc_mac import bqc_pkg::*; #(
	parameter int W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  coef,
	input  logic signed [W-1:0] operand,
	input  logic signed [W-1:0] addend,
	output logic                done,
	output logic signed [W-1:0] result
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_HI,
		M_SAT,
		M_ADD
	} mstate_e;

	localparam logic signed [67:0] PMAX = (68'sd1 <<< (W - 1)) - 68'sd1;
	localparam logic signed [67:0] PMIN = -PMAX - 68'sd1;

	mstate_e             state_q;
	logic                done_q;
	logic signed [64:0]  pl_q;
	logic signed [64:0]  ph_q;
	logic signed [W-1:0] pq_q;
	logic signed [W-1:0] result_q;

	logic signed [63:0]  v_ext;
	logic signed [32:0]  mul_b;
	logic signed [64:0]  prod;
	logic signed [95:0]  full;
	logic signed [67:0]  shifted;
	logic signed [W-1:0] pq_d;
	logic signed [W:0]   sum;
	logic signed [W-1:0] sum_sat;

	assign v_ext = 64'(operand);
	assign mul_b = (state_q == M_IDLE) ? $signed({1'b0, v_ext[31:0]})
	                                    : $signed({v_ext[63], v_ext[63:32]});
	assign prod  = 65'(coef) * 65'(mul_b);

	// Arithmetic shift of the exact product gives the floor.
	assign full    = (96'(ph_q) <<< 32) + 96'(pl_q);
	assign shifted = full[95:28];

	always_comb begin
		if (shifted > PMAX) begin
			pq_d = W'(PMAX);
		end else if (shifted < PMIN) begin
			pq_d = W'(PMIN);
		end else begin
			pq_d = W'(shifted);
		end
	end

	assign sum = (W+1)'(addend) + (W+1)'(pq_q);

	always_comb begin
		if (sum[W] != sum[W-1]) begin
			sum_sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			sum_sat = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_ADD);
			unique case (state_q)
				M_IDLE: if (start) state_q <= M_HI;
				M_HI:   state_q <= M_SAT;
				M_SAT:  state_q <= M_ADD;
				M_ADD:  state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) pl_q <= prod;
		if (state_q == M_HI) ph_q <= prod;
		if (state_q == M_SAT) pq_q <= pq_d;
		if (state_q == M_ADD) result_q <= sum_sat;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ src/bqc_seq.sv @@
// Walks six micro-operations per section over all sections, one at a time.
module bqc_seq import bqc_pkg::*; #(
	parameter int SECTIONS = 5,
	parameter int SECW     = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            mac_done,
	input  logic            out_free,
	output logic            ready,
	output logic [SECW-1:0] sec,
	output seq_ctl_t        ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_DONE
	} sstate_e;

	sstate_e         state_q;
	logic [SECW-1:0] sec_q;
	op_e             op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sec_q   <= '0;
			op_q    <= OP_Y;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_ISSUE;
					sec_q   <= '0;
					op_q    <= OP_Y;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: if (mac_done) begin
					if (op_q == OP_S1) begin
						op_q <= OP_Y;
						if (sec_q == SECW'(SECTIONS - 1)) begin
							state_q <= S_DONE;
						end else begin
							sec_q   <= sec_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end else begin
						op_q    <= op_next(op_q);
						state_q <= S_ISSUE;
					end
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready     = (state_q == S_IDLE);
	assign sec       = sec_q;
	assign ctl.start = (state_q == S_ISSUE);
	assign ctl.emit  = (state_q == S_DONE) && out_free;
	assign ctl.op    = op_q;

endmodule

@@ src/biquad_cascade_filter_top.sv @@
// Channel | Signals                                    | Transaction
// --------+--------------------------------------------+-----------------------------------
// input   | in_valid, in_ready, sample[15:0], restart  | one raw sample, optional restart
// output  | out_valid, out_ready, filtered[15:0]       | one filtered signed Q15 sample
//
// A transaction runs from acceptance to the result register as follows: every
// section runs six multiply-add steps through one shared unit, each from
// issue to write-back before the next is issued, and then the result register
// is loaded. The input is ready again the cycle after that.
// Reset clears all section state; a restart flag clears it again at acceptance.
// A new sample is taken while a result waits; only a result still waiting when
// the next one is finished holds the block until out_ready frees the register.
module biquad_cascade_filter_top import bqc_pkg::*; #(
	parameter int SECTIONS     = 5,
	parameter int SIGNAL_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        sample,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] filtered
);

	localparam int W    = SIGNAL_WIDTH;
	localparam int SECW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int AW   = $clog2(2 * SECTIONS);
	localparam logic [64:0] POS_LIM = (65'd1 << (W - 1)) - 65'd1;

	// Section state file: s0 at even, s1 at odd addresses.
	logic signed [W-1:0] st_q [2*SECTIONS];
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] acc_q;
	logic signed [15:0]  out_q;
	logic                out_valid_q;

	logic                in_fire;
	logic                out_free;
	logic [SECW-1:0]     sec;
	seq_ctl_t            ctl;
	uop_t                uop;
	logic                mac_done;
	logic signed [W-1:0] mac_res;
	logic signed [31:0]  coef;
	logic signed [W-1:0] operand;
	logic signed [W-1:0] addend;
	logic [SECW:0]       i0;
	logic [SECW:0]       i1;
	logic [32:0]         raw;
	logic signed [W-1:0] x_in;
	logic [W:0]          mag;
	logic [W-16:0]       qm;
	logic signed [15:0]  q_out;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	bqc_seq #(
		.SECTIONS(SECTIONS),
		.SECW    (SECW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.mac_done(mac_done),
		.out_free(out_free),
		.ready   (in_ready),
		.sec     (sec),
		.ctl     (ctl)
	);

	// The current step's operands; none of them changes until its result returns.
	assign uop  = uop_of(ctl.op);
	assign coef = coef_of(32'(sec), uop.coef);
	assign i0   = {sec, 1'b0};
	assign i1   = {sec, 1'b1};

	always_comb begin
		unique case (uop.src)
			SRC_X:   operand = x_q;
			SRC_Y:   operand = y_q;
			default: operand = acc_q;
		endcase
		unique case (uop.add)
			ADD_S0:  addend = st_q[i0[AW-1:0]];
			ADD_S1:  addend = st_q[i1[AW-1:0]];
			ADD_ACC: addend = acc_q;
			default: addend = '0;
		endcase
	end

	bqc_mac #(
		.W(W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start),
		.coef   (coef),
		.operand(operand),
		.addend (addend),
		.done   (mac_done),
		.result (mac_res)
	);

	// The sample is an integer moved up by 16 fraction bits, clipped to the signal range.
	assign raw  = {1'b0, sample, 16'h0000};
	assign x_in = (65'(raw) > POS_LIM) ? W'(POS_LIM) : W'(raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2 * SECTIONS; i++) st_q[i] <= '0;
		end else if (in_fire && restart) begin
			for (int i = 0; i < 2 * SECTIONS; i++) st_q[i] <= '0;
		end else if (mac_done) begin
			if (uop.dst == DST_S0) st_q[i0[AW-1:0]] <= mac_res;
			if (uop.dst == DST_S1) st_q[i1[AW-1:0]] <= mac_res;
		end
	end

	// The last step of a section hands its output on as the next section's input.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= x_in;
		end else if (mac_done && ctl.op == OP_S1) begin
			x_q <= y_q;
		end
		if (mac_done && uop.dst == DST_Y) y_q <= mac_res;
		if (mac_done && uop.dst == DST_ACC) acc_q <= mac_res;
	end

	// Drop the fraction toward zero, then clamp to signed Q15.
	always_comb begin
		mag = x_q[W-1] ? ((W+1)'(0) - (W+1)'(x_q)) : (W+1)'(x_q);
		qm  = mag[W:16];
		if (x_q[W-1]) begin
			q_out = (qm > (W-15)'(32768)) ? 16'sh8000 : 16'(0 - qm);
		end else begin
			q_out = (qm > (W-15)'(32767)) ? 16'sh7FFF : 16'(qm);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) out_q <= q_out;
	end

	assign out_valid = out_valid_q;
	assign filtered  = out_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted while a sample is in flight");

	a_mac_latency: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> ##4 mac_done)
		else $error("multiply-add step did not return after four cycles");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> !ctl.start)
		else $error("new step issued during write-back");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && restart |=> st_q[0] == '0)
		else $error("restart did not clear section state");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

// Checks the five-section biquad cascade against a bit-true predictor.
// Each sample transaction that the block accepts is run through the
// predictor at once, and the filtered value it yields joins a queue. Every
// result transaction that leaves the block must match the oldest entry.
module tb;

	localparam int NSEC       = 5;
	localparam int SW         = 48;
	localparam int N_RANDOM   = 1300;
	localparam int LATENCY    = 30 * NSEC + 2;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef logic signed [SW-1:0] sig_t;
	typedef logic signed [95:0] wide_t;

	localparam wide_t SIG_MAX = (96'sd1 <<< (SW - 1)) - 96'sd1;
	localparam wide_t SIG_MIN = -(96'sd1 <<< (SW - 1));

	// Columns b0, b1, b2, -a1, -a2 in signed Q4.28, one row per section.
	localparam logic signed [31:0] BQ_COEF [5][5] = '{
		'{32'sd147504, -32'sd295009, 32'sd147504, -32'sd208239557, -32'sd156314714},
		'{32'sd268435456, -32'sd536870912, 32'sd268435456, -32'sd148770661,
			-32'sd169236430},
		'{32'sd268435456, 32'sd0, -32'sd268435456, -32'sd278033113, -32'sd182786864},
		'{32'sd268435456, 32'sd536870912, 32'sd268435456, -32'sd121451890,
			-32'sd225400456},
		'{32'sd268435456, 32'sd536870912, 32'sd268435456, -32'sd340380561,
			-32'sd235077388}
	};

	// Shapes of the random sample stream, picked per segment.
	typedef enum logic [1:0] {
		SEG_NOISE,
		SEG_HOLD,
		SEG_SQUARE,
		SEG_RAMP
	} seg_e;

	// One row of the directed stimulus. Where has_lit is set, the row's
	// filtered value is obvious and is typed in rather than predicted.
	typedef struct packed {
		logic [15:0]        smp;
		logic               rst;
		logic               has_lit;
		logic signed [15:0] lit;
	} stim_row_t;

	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// Zero input on cleared state must give zero.
		'{16'd0,     1'b1, 1'b1, 16'sd0},
		'{16'd0,     1'b0, 1'b1, 16'sd0},
		// Full-scale step, then held, to drive the sections hard.
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		// Full-scale square wave at the Nyquist rate.
		'{16'h0000,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'h0000,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b0, 1'b0, 16'sd0},
		'{16'h0000,  1'b0, 1'b0, 16'sd0},
		// Restart in the middle of a stream, with mid-scale and small values.
		'{16'h8000,  1'b1, 1'b0, 16'sd0},
		'{16'h0001,  1'b0, 1'b0, 16'sd0},
		'{16'h7FFF,  1'b0, 1'b0, 16'sd0},
		'{16'hFFFF,  1'b1, 1'b0, 16'sd0},
		// A restart with a zero sample throws away all history.
		'{16'h0000,  1'b1, 1'b1, 16'sd0},
		'{16'h0000,  1'b0, 1'b1, 16'sd0},
		// Alternating bit patterns.
		'{16'hAAAA,  1'b0, 1'b0, 16'sd0},
		'{16'h5555,  1'b0, 1'b0, 16'sd0},
		'{16'hAAAA,  1'b0, 1'b0, 16'sd0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        sample;
	logic               restart;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] filtered;

	// Predictor state: s0 and s1 of each section, interleaved.
	sig_t bq_state [2*NSEC];

	logic signed [15:0] filt_expected [$];
	int                 err_count;
	int                 cycle_count;

	// Sender burst bookkeeping.
	int burst_left;

	biquad_cascade_filter_top #(
		.SECTIONS    (NSEC),
		.SIGNAL_WIDTH(SW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.restart  (restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered (filtered)
	);

	always #10 clk = ~clk;

	function automatic sig_t clamp_sig(wide_t v);
		if (v > SIG_MAX)
			return SIG_MAX[SW-1:0];
		if (v < SIG_MIN)
			return SIG_MIN[SW-1:0];
		return v[SW-1:0];
	endfunction

	// Coefficient times signal, floored back to 16 fraction bits.
	function automatic sig_t coef_mul(logic signed [31:0] c, sig_t v);
		wide_t wc;
		wide_t wv;
		wc = c;
		wv = v;
		return clamp_sig((wc * wv) >>> 28);
	endfunction

	function automatic sig_t sat_sum(sig_t a, sig_t b);
		wide_t wa;
		wide_t wb;
		wa = a;
		wb = b;
		return clamp_sig(wa + wb);
	endfunction

	// Sections beyond the five-row table pass the signal unchanged.
	function automatic logic signed [31:0] section_coef(int sec, int k);
		if (sec < 5)
			return BQ_COEF[sec][k];
		return (k == 0) ? 32'sh1000_0000 : 32'sd0;
	endfunction

	// Runs one sample through the cascade and returns the Q15 output.
	function automatic logic signed [15:0] cascade_step(logic [15:0] smp, logic rst);
		sig_t        x;
		sig_t        y;
		logic [SW-1:0] mag;
		logic [SW-1:0] q;
		if (rst) begin
			foreach (bq_state[i])
				bq_state[i] = '0;
		end
		x = sig_t'({{(SW-32){1'b0}}, smp, 16'd0});
		for (int j = 0; j < NSEC; j++) begin
			y = sat_sum(coef_mul(section_coef(j, 0), x), bq_state[2*j]);
			bq_state[2*j] = sat_sum(sat_sum(coef_mul(section_coef(j, 1), x),
				coef_mul(section_coef(j, 3), y)), bq_state[2*j+1]);
			bq_state[2*j+1] = sat_sum(coef_mul(section_coef(j, 2), x),
				coef_mul(section_coef(j, 4), y));
			x = y;
		end
		// Truncate toward zero, then clamp to the Q15 range.
		if (x < 0) begin
			mag = -x;
			q = mag >> 16;
			if (q > 32768)
				q = 32768;
			return -$signed(q[15:0]);
		end
		q = x >> 16;
		if (q > 32767)
			q = 32767;
		return q[15:0];
	endfunction

	// Offers one sample transaction and waits until the block takes it. The
	// sender runs in bursts; before most new bursts it idles for a random gap so
	// that the next sample lands on a different phase of the block's work.
	task automatic send_sample(logic [15:0] smp, logic rst, logic has_lit,
			logic signed [15:0] lit);
		int gap;
		logic signed [15:0] predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample   <= smp;
		restart  <= rst;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predicted = cascade_step(smp, rst);
		filt_expected.push_back(has_lit ? lit : predicted);
		@(negedge clk);
	endtask

	// Cycle limit: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result checker: each result transaction is compared with the oldest
	// expectation. A result with nothing waiting is a failure by itself.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (filt_expected.size() == 0) begin
				$error("filtered: expected none, actual %0d", filtered);
				err_count++;
			end else begin
				logic signed [15:0] want;
				want = filt_expected.pop_front();
				if (filtered !== want) begin
					$error("filtered: expected %0d, actual %0d", want, filtered);
					err_count++;
				end
			end
		end
	end

	// Receiver: out_ready alternates between long ready stretches and stalls
	// of random length. About a quarter of the time a ready stretch is
	// followed by another one, which gives calm periods with no stalls.
	initial begin
		logic ready_lvl;
		int   hold_left;
		ready_lvl = 1'b1;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_left == 0) begin
				if (ready_lvl && $urandom_range(0, 3) != 0) begin
					ready_lvl = 1'b0;
					hold_left = $urandom_range(1, 40);
				end else begin
					ready_lvl = 1'b1;
					hold_left = $urandom_range(1, 200);
				end
			end
			@(negedge clk);
			out_ready <= ready_lvl;
			hold_left--;
		end
	end

	// Stimulus and end of run.
	initial begin
		seg_e        seg_mode;
		int          seg_left;
		int          ramp_step;
		logic [15:0] level;
		logic [15:0] smp;
		logic        rst;
		logic        sq_phase;

		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		restart     = 1'b0;
		err_count   = 0;
		cycle_count = 0;
		burst_left  = 0;
		seg_left    = 0;
		seg_mode    = SEG_NOISE;
		level       = '0;
		ramp_step   = 1;
		sq_phase    = 1'b0;
		foreach (bq_state[i])
			bq_state[i] = '0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows first.
		for (int r = 0; r < N_DIRECTED; r++)
			send_sample(DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].rst,
				DIRECTED_ROWS[r].has_lit, DIRECTED_ROWS[r].lit);

		// Random part, built from segments of differing shape: white noise,
		// a held level with a little noise, full-scale square waves of random
		// period, and ramps. Restarts are scattered through all of them.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (seg_left == 0) begin
				seg_mode  = seg_e'($urandom_range(0, 3));
				seg_left  = $urandom_range(5, 60);
				level     = 16'($urandom);
				ramp_step = $urandom_range(1, 4000);
			end
			seg_left--;
			case (seg_mode)
				SEG_NOISE: begin
					smp = 16'($urandom);
				end
				SEG_HOLD: begin
					smp = level ^ 16'($urandom_range(0, 255));
				end
				SEG_SQUARE: begin
					if ($urandom_range(0, 2) == 0)
						sq_phase = ~sq_phase;
					smp = sq_phase ? 16'hFFFF : 16'h0000;
				end
				default: begin
					level = level + 16'(ramp_step);
					smp   = level;
				end
			endcase
			rst = ($urandom_range(0, 49) == 0);
			send_sample(smp, rst, 1'b0, 16'sd0);
		end
		in_valid <= 1'b0;

		// Drain, then give a spurious result time to show up.
		while (filt_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 50) @(posedge clk);

		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
